### hw/rtl/tick_counter_cpu_load_meter_core_macros.svh
// Assertion macros for the tick counter / load meter core.
// Expects signals named clk and rst in the including scope.
`ifndef TICK_COUNTER_CPU_LOAD_METER_CORE_MACROS_SVH
`define TICK_COUNTER_CPU_LOAD_METER_CORE_MACROS_SVH

// same-cycle implication
`define LMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lmc_pkg.sv
// Shared types, command codes and helpers for the load meter core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lmc_pkg;

  localparam int TICK_W    = 32;
  localparam int ELAPSED_W = 32;
  localparam int PCT_W     = 7;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ANNOUNCE = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;

  typedef struct packed {
    logic [1:0]           command;
    logic                 idle_running;
    logic [ELAPSED_W-1:0] elapsed;
  } cmd_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic [PCT_W-1:0]  usage_percent;
    logic              usage_valid;
  } res_item_t;

  // start request for the serial counter bank
  typedef struct packed {
    logic start;
    logic is_tick;
    logic idle;
  } cnt_ctl_t;

  // one bit of a serial adder: {carry, sum}
  function automatic logic [1:0] full_add(input logic a, input logic b, input logic c);
    full_add = {(a & b) | (a & c) | (b & c), a ^ b ^ c};
  endfunction

  // one bit of a serial subtractor a - b: {borrow, diff}
  function automatic logic [1:0] full_sub(input logic a, input logic b, input logic c);
    full_sub = {(~a & b) | (~(a ^ b) & c), a ^ b ^ c};
  endfunction

endpackage

### hw/rtl/lmc_counters.sv
// Bit-serial counter bank: tick total, window total and window idle.
// Uses lmc_pkg for the control struct and the serial adder bit.
`timescale 1ns / 1ps

module lmc_counters #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lmc_pkg::cnt_ctl_t               ctl,
  input  logic [lmc_pkg::ELAPSED_W-1:0]   elapsed,
  input  logic                            clear,
  output logic                            done,
  output logic [lmc_pkg::TICK_W-1:0]      tick_count,
  output logic [COUNT_WIDTH-1:0]          win_total,
  output logic [COUNT_WIDTH-1:0]          win_idle
);

  localparam int CW = $clog2(COUNT_WIDTH);

  logic [COUNT_WIDTH-1:0] tick_sr;
  logic [COUNT_WIDTH-1:0] tot_sr;
  logic [COUNT_WIDTH-1:0] idl_sr;
  logic [COUNT_WIDTH-1:0] add_sr;
  logic                   idle_en;
  logic                   running;
  logic [CW-1:0]          bit_cnt;
  logic                   c_tick;
  logic                   c_tot;
  logic                   c_idl;

  logic [COUNT_WIDTH+lmc_pkg::ELAPSED_W-1:0] elapsed_wide;
  logic [COUNT_WIDTH+lmc_pkg::TICK_W-1:0]    tick_wide;
  logic [1:0] r_tick;
  logic [1:0] r_tot;
  logic [1:0] r_idl;
  logic       add_bit;

  assign elapsed_wide = {{COUNT_WIDTH{1'b0}}, elapsed};
  assign tick_wide    = {{lmc_pkg::TICK_W{1'b0}}, tick_sr};
  assign tick_count   = tick_wide[lmc_pkg::TICK_W-1:0];
  assign win_total    = tot_sr;
  assign win_idle     = idl_sr;

  assign add_bit = add_sr[0];
  assign r_tick  = lmc_pkg::full_add(tick_sr[0], add_bit, c_tick);
  assign r_tot   = lmc_pkg::full_add(tot_sr[0], add_bit, c_tot);
  assign r_idl   = lmc_pkg::full_add(idl_sr[0], add_bit & idle_en, c_idl);

  assign done = running && (bit_cnt == CW'(COUNT_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      bit_cnt <= '0;
      tick_sr <= '0;
      tot_sr  <= '0;
      idl_sr  <= '0;
      c_tick  <= 1'b0;
      c_tot   <= 1'b0;
      c_idl   <= 1'b0;
    end else if (ctl.start) begin
      running <= 1'b1;
      bit_cnt <= '0;
      c_tick  <= 1'b0;
      c_tot   <= 1'b0;
      c_idl   <= 1'b0;
      add_sr  <= ctl.is_tick ? COUNT_WIDTH'(1) : elapsed_wide[COUNT_WIDTH-1:0];
      idle_en <= ctl.is_tick ? ctl.idle : 1'b1;
    end else if (clear) begin
      tot_sr <= '0;
      idl_sr <= '0;
    end else if (running) begin
      // LSB first; after COUNT_WIDTH shifts each register holds its new sum
      tick_sr <= {r_tick[0], tick_sr[COUNT_WIDTH-1:1]};
      tot_sr  <= {r_tot[0], tot_sr[COUNT_WIDTH-1:1]};
      idl_sr  <= {r_idl[0], idl_sr[COUNT_WIDTH-1:1]};
      add_sr  <= {1'b0, add_sr[COUNT_WIDTH-1:1]};
      c_tick  <= r_tick[1];
      c_tot   <= r_tot[1];
      c_idl   <= r_idl[1];
      bit_cnt <= bit_cnt + CW'(1);
      if (done) begin
        running <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/lmc_serial_divider.sv
// Bit-serial busy-percent unit: busy = total - min(idle, total),
// then floor(busy * 100 / total) by serial restoring division. Uses lmc_pkg.
`timescale 1ns / 1ps

module lmc_serial_divider #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COUNT_WIDTH-1:0]        total,
  input  logic [COUNT_WIDTH-1:0]        idle,
  output logic                          done,
  output logic [lmc_pkg::PCT_W-1:0]     percent
);

  localparam int NW = COUNT_WIDTH + lmc_pkg::PCT_W;   // width of busy * 100
  localparam int KW = $clog2(NW);

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_SUB  = 6'b000010,
    D_MUL  = 6'b000100,
    D_LOAD = 6'b001000,
    D_STEP = 6'b010000,
    D_DONE = 6'b100000
  } div_state_t;

  div_state_t state;

  logic [COUNT_WIDTH-1:0]   tot_sr;
  logic [COUNT_WIDTH-1:0]   idl_sr;
  logic [COUNT_WIDTH-1:0]   bsy_sr;
  logic [5:0]               hist;
  logic [1:0]               mc;
  logic [NW-1:0]            n_sr;
  logic [COUNT_WIDTH-1:0]   rem;
  logic [COUNT_WIDTH:0]     s_sr;
  logic [COUNT_WIDTH:0]     d_sr;
  logic                     brw;
  logic                     nz;
  logic [2:0]               qi;
  logic [KW-1:0]            k;
  logic [lmc_pkg::PCT_W-1:0] quo;

  logic [1:0]             sub_r;
  logic [1:0]             step_r;
  logic [2:0]             msum;
  logic                   k_last;
  logic [COUNT_WIDTH-1:0] cur_rem;
  logic [lmc_pkg::PCT_W-1:0] n_low;

  assign sub_r  = lmc_pkg::full_sub(tot_sr[0], idl_sr[0], brw);
  assign k_last = (k == KW'(COUNT_WIDTH));
  assign step_r = lmc_pkg::full_sub(s_sr[0], tot_sr[0] & ~k_last, brw);
  // busy * 100 = (busy << 6) + (busy << 5) + (busy << 2)
  assign msum   = {2'b00, hist[1]} + {2'b00, hist[4]} + {2'b00, hist[5]} + {1'b0, mc};
  // quotient never reaches 128, so the top of busy * 100 is below total
  assign cur_rem = (qi == 3'd6) ? n_sr[NW-1:lmc_pkg::PCT_W] : rem;
  // low dividend bits, brought down one per division step
  assign n_low   = n_sr[lmc_pkg::PCT_W-1:0];

  assign done    = (state == D_DONE);
  assign percent = nz ? quo : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            tot_sr <= total;
            idl_sr <= idle;
            k      <= '0;
            brw    <= 1'b0;
            nz     <= 1'b0;
            qi     <= 3'd6;
            state  <= D_SUB;
          end
        end
        D_SUB: begin
          tot_sr <= {tot_sr[0], tot_sr[COUNT_WIDTH-1:1]};
          idl_sr <= {1'b0, idl_sr[COUNT_WIDTH-1:1]};
          bsy_sr <= {sub_r[0], bsy_sr[COUNT_WIDTH-1:1]};
          brw    <= sub_r[1];
          nz     <= nz | tot_sr[0];
          k      <= k + KW'(1);
          if (k == KW'(COUNT_WIDTH - 1)) begin
            // idle above total clamps busy to zero
            if (sub_r[1]) begin
              bsy_sr <= '0;
            end
            k     <= '0;
            hist  <= '0;
            mc    <= '0;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          bsy_sr <= {1'b0, bsy_sr[COUNT_WIDTH-1:1]};
          hist   <= {hist[4:0], bsy_sr[0]};
          n_sr   <= {msum[0], n_sr[NW-1:1]};
          mc     <= msum[2:1];
          k      <= k + KW'(1);
          if (k == KW'(NW - 1)) begin
            state <= D_LOAD;
          end
        end
        D_LOAD: begin
          s_sr  <= {cur_rem, n_low[qi]};
          k     <= '0;
          brw   <= 1'b0;
          state <= D_STEP;
        end
        D_STEP: begin
          s_sr <= {s_sr[0], s_sr[COUNT_WIDTH:1]};
          d_sr <= {step_r[0], d_sr[COUNT_WIDTH:1]};
          brw  <= step_r[1];
          k    <= k + KW'(1);
          if (!k_last) begin
            tot_sr <= {tot_sr[0], tot_sr[COUNT_WIDTH-1:1]};
          end else begin
            // borrow out: partial remainder below divisor, keep it
            rem <= step_r[1] ? s_sr[COUNT_WIDTH:1] : d_sr[COUNT_WIDTH:1];
            quo <= {quo[lmc_pkg::PCT_W-2:0], ~step_r[1]};
            if (qi == 3'd0) begin
              state <= D_DONE;
            end else begin
              qi    <= qi - 3'd1;
              state <= D_LOAD;
            end
          end
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/tick_counter_cpu_load_meter_core.sv
// Tick counter and CPU load meter, top level.
// Depends on lmc_pkg, lmc_counters, lmc_serial_divider and the macros header.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall / cmd_item) takes one transaction
//   at a time: tick, announce (add elapsed), usage query, or an unused code.
//   Result channel (res_valid / res_stall / res_item) returns exactly one
//   transaction per command: the tick count after the command, and on a query
//   the busy percentage since the previous query with usage_valid set.
// What sets the time from acceptance to res_valid; the next command can be
// accepted in the cycle in which res_valid rises:
//   tick / announce: the bit-serial adders.
//   query: the serial subtract, the serial x100 pass
//   and seven restoring division steps.
//   unused code: no counter or divider work.
// One command is in work at a time; cmd_stall is high from acceptance until
// the result is placed in the output register. A command may be accepted
// while the previous result still waits; if the receiver keeps stalling,
// the finished result waits inside until the output register frees.
// Reset clears all counters and empties the output register.
`timescale 1ns / 1ps
`include "tick_counter_cpu_load_meter_core_macros.svh"

module tick_counter_cpu_load_meter_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  lmc_pkg::cmd_item_t  cmd_item,
  output logic                res_valid,
  input  logic                res_stall,
  output lmc_pkg::res_item_t  res_item
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CNT  = 4'b0010,
    S_DIV  = 4'b0100,
    S_WAIT = 4'b1000
  } top_state_t;

  top_state_t state;
  logic       pend_query;

  logic                          accept;
  logic                          out_free;
  lmc_pkg::cnt_ctl_t             cnt_ctl;
  logic                          cnt_done;
  logic                          div_start;
  logic                          div_done;
  logic [lmc_pkg::TICK_W-1:0]    tick_count;
  logic [COUNT_WIDTH-1:0]        win_total;
  logic [COUNT_WIDTH-1:0]        win_idle;
  logic [lmc_pkg::PCT_W-1:0]     percent;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;

  assign cnt_ctl.start   = accept && ((cmd_item.command == lmc_pkg::CMD_TICK) ||
                                      (cmd_item.command == lmc_pkg::CMD_ANNOUNCE));
  assign cnt_ctl.is_tick = (cmd_item.command == lmc_pkg::CMD_TICK);
  assign cnt_ctl.idle    = cmd_item.idle_running;
  assign div_start       = accept && (cmd_item.command == lmc_pkg::CMD_QUERY);

  lmc_counters #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counters (
    .clk        (clk),
    .rst        (rst),
    .ctl        (cnt_ctl),
    .elapsed    (cmd_item.elapsed),
    .clear      (div_start),
    .done       (cnt_done),
    .tick_count (tick_count),
    .win_total  (win_total),
    .win_idle   (win_idle)
  );

  lmc_serial_divider #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .total   (win_total),
    .idle    (win_idle),
    .done    (div_done),
    .percent (percent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_query <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_query <= (cmd_item.command == lmc_pkg::CMD_QUERY);
            priority if (cnt_ctl.start) begin
              state <= S_CNT;
            end else if (div_start) begin
              state <= S_DIV;
            end else begin
              state <= S_WAIT;
            end
          end
        end
        S_CNT: begin
          if (cnt_done) begin
            state <= S_WAIT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WAIT) && out_free) begin
      res_item.tick_count    <= tick_count;
      res_item.usage_percent <= pend_query ? percent : '0;
      res_item.usage_valid   <= pend_query;
    end
  end

  `LMC_ASSERT_NEXT(a_busy_after_accept, accept, cmd_stall, "no stall after accepted command")
  `LMC_ASSERT_SAME(a_div_done_in_div, div_done, state == S_DIV, "divider done outside query")
  `LMC_ASSERT_SAME(a_cnt_done_in_cnt, cnt_done, state == S_CNT, "counter done outside count")

endmodule
